/* rtl/ems2cal_pkg.sv */
package ems2cal_pkg;

   // Number of register stages between the request port and the result port.
   localparam int NUM_STAGES = 14;

   // Latest representable instant: 2100-01-01 00:00:00.000 in milliseconds.
   localparam logic [41:0] MAX_MILLIS = 42'd4102444800000;

   // Divisors and their scaled reciprocals (floor of 2^32 or 2^40 over the divisor).
   localparam logic [9:0]  MS_PER_SEC      = 10'd1000;
   localparam logic [22:0] RECIP_MS        = 23'd4294967;
   localparam logic [26:0] FOUR_YEAR_SEC   = 27'd126230400;
   localparam logic [13:0] RECIP_FOUR_YEAR = 14'd8710;
   localparam logic [16:0] DAY_SEC         = 17'd86400;
   localparam logic [15:0] RECIP_DAY       = 16'd49710;
   localparam logic [11:0] HOUR_SEC        = 12'd3600;
   localparam logic [20:0] RECIP_HOUR      = 21'd1193046;
   localparam logic [5:0]  MIN_SEC         = 6'd60;
   localparam logic [26:0] RECIP_MIN       = 27'd71582788;

   // Year boundaries inside a four-year block; the third year is the leap year.
   localparam logic [26:0] ONE_YEAR_SEC   = 27'd31536000;
   localparam logic [26:0] TWO_YEAR_SEC   = 27'd63072000;
   localparam logic [26:0] THREE_YEAR_SEC = 27'd94694400;

   // Largest year offset that the block can report.
   localparam logic [7:0] MAX_YEARS = 8'd130;

   typedef logic [8:0] yday_type;

   // Cumulative days at the end of each month.
   localparam yday_type CUM_NORMAL [12] = '{
      9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
   localparam yday_type CUM_LEAP [12] = '{
      9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
      9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

endpackage

/* rtl/epoch_ms_to_calendar.sv */
// Throughput: one item per cycle while rsp_ready is high; each constant division
// is a reciprocal multiply stage followed by a correction stage, and these make
// up most of the depth.
// Stalls on the result side back up stage by stage, so bubbles are squeezed out.
// Reset (synchronous, active high) clears the stage valid bits only.
module epoch_ms_to_calendar (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_epoch_millis,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_years_since_1970,
   output logic [3:0]  rsp_month_number,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour_of_day,
   output logic [5:0]  rsp_minute_of_hour,
   output logic [5:0]  rsp_second_of_minute,
   output logic [9:0]  rsp_milli_part,
   output logic        rsp_was_clamped
);
   import ems2cal_pkg::*;

   // ---------------------------------------------------------------
   // Pipeline control: a stage loads when it is empty or its successor loads.
   // ---------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] valid_src;
   logic [NUM_STAGES:0]   stage_rdy;

   assign valid_src = {valid_ff[NUM_STAGES-2:0], req_valid};

   always_comb begin
      stage_rdy[NUM_STAGES] = rsp_ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         valid_in[k] = stage_rdy[k] ? valid_src[k] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_rdy[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // ---------------------------------------------------------------
   // Stage 1: saturate the input at the first instant of 2100.
   // ---------------------------------------------------------------
   logic [41:0] s1_ms_ff, s1_ms_in;
   logic        s1_clamp_ff, s1_clamp_in;

   assign s1_clamp_in = req_epoch_millis > {22'd0, MAX_MILLIS};
   assign s1_ms_in    = s1_clamp_in ? MAX_MILLIS : req_epoch_millis[41:0];

   always_ff @(posedge clock) begin
      if (stage_rdy[0]) begin
         s1_ms_ff    <= s1_ms_in;
         s1_clamp_ff <= s1_clamp_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: estimate the upper 21 bits divided by 1000.
   // ---------------------------------------------------------------
   logic [43:0] s2_prod;
   logic [11:0] s2_qa_ff, s2_qa_in;
   logic [41:0] s2_ms_ff;
   logic        s2_clamp_ff;

   assign s2_prod  = 44'(s1_ms_ff[41:21]) * 44'(RECIP_MS);
   assign s2_qa_in = s2_prod[43:32];

   always_ff @(posedge clock) begin
      if (stage_rdy[1]) begin
         s2_qa_ff    <= s2_qa_in;
         s2_ms_ff    <= s1_ms_ff;
         s2_clamp_ff <= s1_clamp_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: correct the upper quotient and keep its remainder.
   // ---------------------------------------------------------------
   logic [21:0] s3_rest;
   logic        s3_fix;
   logic [11:0] s3_qa_ff, s3_qa_in;
   logic [9:0]  s3_ra_ff, s3_ra_in;
   logic [20:0] s3_b_ff;
   logic        s3_clamp_ff;

   assign s3_rest  = 22'(s2_ms_ff[41:21]) - 22'(s2_qa_ff) * 22'(MS_PER_SEC);
   assign s3_fix   = s3_rest >= 22'(MS_PER_SEC);
   assign s3_qa_in = s2_qa_ff + 12'(s3_fix);
   assign s3_ra_in = s3_fix ? 10'(s3_rest - 22'(MS_PER_SEC)) : s3_rest[9:0];

   always_ff @(posedge clock) begin
      if (stage_rdy[2]) begin
         s3_qa_ff    <= s3_qa_in;
         s3_ra_ff    <= s3_ra_in;
         s3_b_ff     <= s2_ms_ff[20:0];
         s3_clamp_ff <= s2_clamp_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: estimate the lower part (remainder and low bits) over 1000.
   // ---------------------------------------------------------------
   logic [30:0] s4_x_in;
   logic [53:0] s4_prod;
   logic [30:0] s4_x_ff;
   logic [20:0] s4_q_ff, s4_q_in;
   logic [11:0] s4_qa_ff;
   logic        s4_clamp_ff;

   assign s4_x_in = {s3_ra_ff, s3_b_ff};
   assign s4_prod = 54'(s4_x_in) * 54'(RECIP_MS);
   assign s4_q_in = s4_prod[52:32];

   always_ff @(posedge clock) begin
      if (stage_rdy[3]) begin
         s4_x_ff     <= s4_x_in;
         s4_q_ff     <= s4_q_in;
         s4_qa_ff    <= s3_qa_ff;
         s4_clamp_ff <= s3_clamp_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: correct, giving whole seconds and the millisecond part.
   // ---------------------------------------------------------------
   logic [31:0] s5_rest;
   logic        s5_fix;
   logic [20:0] s5_q;
   logic [31:0] s5_secs_ff, s5_secs_in;
   logic [9:0]  s5_milli_ff, s5_milli_in;
   logic        s5_clamp_ff;

   assign s5_rest     = 32'(s4_x_ff) - 32'(s4_q_ff) * 32'(MS_PER_SEC);
   assign s5_fix      = s5_rest >= 32'(MS_PER_SEC);
   assign s5_q        = s4_q_ff + 21'(s5_fix);
   assign s5_milli_in = s5_fix ? 10'(s5_rest - 32'(MS_PER_SEC)) : s5_rest[9:0];
   assign s5_secs_in  = {s4_qa_ff[10:0], s5_q};

   always_ff @(posedge clock) begin
      if (stage_rdy[4]) begin
         s5_secs_ff  <= s5_secs_in;
         s5_milli_ff <= s5_milli_in;
         s5_clamp_ff <= s4_clamp_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 6: estimate the number of four-year blocks.
   // ---------------------------------------------------------------
   logic [45:0] s6_prod;
   logic [5:0]  s6_q4_ff, s6_q4_in;
   logic [31:0] s6_secs_ff;
   logic [9:0]  s6_milli_ff;
   logic        s6_clamp_ff;

   assign s6_prod  = 46'(s5_secs_ff) * 46'(RECIP_FOUR_YEAR);
   assign s6_q4_in = s6_prod[45:40];

   always_ff @(posedge clock) begin
      if (stage_rdy[5]) begin
         s6_q4_ff    <= s6_q4_in;
         s6_secs_ff  <= s5_secs_ff;
         s6_milli_ff <= s5_milli_ff;
         s6_clamp_ff <= s5_clamp_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 7: correct the block count and find seconds into the block.
   // ---------------------------------------------------------------
   logic [31:0] s7_rest;
   logic        s7_fix;
   logic [5:0]  s7_q4_ff, s7_q4_in;
   logic [26:0] s7_rem_ff, s7_rem_in;
   logic [9:0]  s7_milli_ff;
   logic        s7_clamp_ff;

   assign s7_rest   = s6_secs_ff - 32'(s6_q4_ff) * 32'(FOUR_YEAR_SEC);
   assign s7_fix    = s7_rest >= 32'(FOUR_YEAR_SEC);
   assign s7_q4_in  = s6_q4_ff + 6'(s7_fix);
   assign s7_rem_in = s7_fix ? 27'(s7_rest - 32'(FOUR_YEAR_SEC)) : s7_rest[26:0];

   always_ff @(posedge clock) begin
      if (stage_rdy[6]) begin
         s7_q4_ff    <= s7_q4_in;
         s7_rem_ff   <= s7_rem_in;
         s7_milli_ff <= s6_milli_ff;
         s7_clamp_ff <= s6_clamp_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 8: pick the year within the block and note the leap year.
   // ---------------------------------------------------------------
   logic        s8_ge1, s8_ge2, s8_ge3;
   logic [1:0]  s8_yoff;
   logic [26:0] s8_base;
   logic [7:0]  s8_years_ff, s8_years_in;
   logic [24:0] s8_remy_ff, s8_remy_in;
   logic        s8_leap_ff, s8_leap_in;
   logic [9:0]  s8_milli_ff;
   logic        s8_clamp_ff;

   assign s8_ge1 = s7_rem_ff >= ONE_YEAR_SEC;
   assign s8_ge2 = s7_rem_ff >= TWO_YEAR_SEC;
   assign s8_ge3 = s7_rem_ff >= THREE_YEAR_SEC;

   always_comb begin
      if (s8_ge3) begin
         s8_yoff = 2'd3;
         s8_base = THREE_YEAR_SEC;
      end else if (s8_ge2) begin
         s8_yoff = 2'd2;
         s8_base = TWO_YEAR_SEC;
      end else if (s8_ge1) begin
         s8_yoff = 2'd1;
         s8_base = ONE_YEAR_SEC;
      end else begin
         s8_yoff = 2'd0;
         s8_base = '0;
      end
   end

   assign s8_leap_in  = s8_ge2 && !s8_ge3;
   assign s8_remy_in  = 25'(s7_rem_ff - s8_base);
   assign s8_years_in = {s7_q4_ff, s8_yoff};

   always_ff @(posedge clock) begin
      if (stage_rdy[7]) begin
         s8_years_ff <= s8_years_in;
         s8_remy_ff  <= s8_remy_in;
         s8_leap_ff  <= s8_leap_in;
         s8_milli_ff <= s7_milli_ff;
         s8_clamp_ff <= s7_clamp_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 9: estimate the day of the year.
   // ---------------------------------------------------------------
   logic [40:0] s9_prod;
   logic [8:0]  s9_yday_ff, s9_yday_in;
   logic [24:0] s9_remy_ff;
   logic [7:0]  s9_years_ff;
   logic        s9_leap_ff;
   logic [9:0]  s9_milli_ff;
   logic        s9_clamp_ff;

   assign s9_prod    = 41'(s8_remy_ff) * 41'(RECIP_DAY);
   assign s9_yday_in = s9_prod[40:32];

   always_ff @(posedge clock) begin
      if (stage_rdy[8]) begin
         s9_yday_ff  <= s9_yday_in;
         s9_remy_ff  <= s8_remy_ff;
         s9_years_ff <= s8_years_ff;
         s9_leap_ff  <= s8_leap_ff;
         s9_milli_ff <= s8_milli_ff;
         s9_clamp_ff <= s8_clamp_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 10: correct the day of the year and keep seconds into the day.
   // ---------------------------------------------------------------
   logic [24:0] s10_rest;
   logic        s10_fix;
   logic [8:0]  s10_yday_ff, s10_yday_in;
   logic [16:0] s10_remd_ff, s10_remd_in;
   logic [7:0]  s10_years_ff;
   logic        s10_leap_ff;
   logic [9:0]  s10_milli_ff;
   logic        s10_clamp_ff;

   assign s10_rest    = s9_remy_ff - 25'(s9_yday_ff) * 25'(DAY_SEC);
   assign s10_fix     = s10_rest >= 25'(DAY_SEC);
   assign s10_yday_in = s9_yday_ff + 9'(s10_fix);
   assign s10_remd_in = s10_fix ? 17'(s10_rest - 25'(DAY_SEC)) : s10_rest[16:0];

   always_ff @(posedge clock) begin
      if (stage_rdy[9]) begin
         s10_yday_ff  <= s10_yday_in;
         s10_remd_ff  <= s10_remd_in;
         s10_years_ff <= s9_years_ff;
         s10_leap_ff  <= s9_leap_ff;
         s10_milli_ff <= s9_milli_ff;
         s10_clamp_ff <= s9_clamp_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 11: month and day from the tables; estimate the hour.
   // ---------------------------------------------------------------
   yday_type    s11_prev;
   logic [3:0]  s11_midx;
   logic [3:0]  s11_month_ff, s11_month_in;
   logic [4:0]  s11_day_ff, s11_day_in;
   logic [37:0] s11_prod;
   logic [4:0]  s11_hour_ff, s11_hour_in;
   logic [16:0] s11_remd_ff;
   logic [7:0]  s11_years_ff;
   logic [9:0]  s11_milli_ff;
   logic        s11_clamp_ff;

   always_comb begin
      s11_midx = '0;
      s11_prev = '0;
      for (int i = 0; i < 11; i++) begin
         if (s10_yday_ff >= (s10_leap_ff ? CUM_LEAP[i] : CUM_NORMAL[i])) begin
            s11_midx = 4'(i + 1);
            s11_prev = s10_leap_ff ? CUM_LEAP[i] : CUM_NORMAL[i];
         end
      end
   end

   assign s11_month_in = s11_midx + 4'd1;
   assign s11_day_in   = 5'(s10_yday_ff - s11_prev + 9'd1);
   assign s11_prod     = 38'(s10_remd_ff) * 38'(RECIP_HOUR);
   assign s11_hour_in  = s11_prod[36:32];

   always_ff @(posedge clock) begin
      if (stage_rdy[10]) begin
         s11_month_ff <= s11_month_in;
         s11_day_ff   <= s11_day_in;
         s11_hour_ff  <= s11_hour_in;
         s11_remd_ff  <= s10_remd_ff;
         s11_years_ff <= s10_years_ff;
         s11_milli_ff <= s10_milli_ff;
         s11_clamp_ff <= s10_clamp_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 12: correct the hour and keep seconds into the hour.
   // ---------------------------------------------------------------
   logic [16:0] s12_rest;
   logic        s12_fix;
   logic [4:0]  s12_hour_ff, s12_hour_in;
   logic [11:0] s12_remh_ff, s12_remh_in;
   logic [3:0]  s12_month_ff;
   logic [4:0]  s12_day_ff;
   logic [7:0]  s12_years_ff;
   logic [9:0]  s12_milli_ff;
   logic        s12_clamp_ff;

   assign s12_rest    = s11_remd_ff - 17'(s11_hour_ff) * 17'(HOUR_SEC);
   assign s12_fix     = s12_rest >= 17'(HOUR_SEC);
   assign s12_hour_in = s11_hour_ff + 5'(s12_fix);
   assign s12_remh_in = s12_fix ? 12'(s12_rest - 17'(HOUR_SEC)) : s12_rest[11:0];

   always_ff @(posedge clock) begin
      if (stage_rdy[11]) begin
         s12_hour_ff  <= s12_hour_in;
         s12_remh_ff  <= s12_remh_in;
         s12_month_ff <= s11_month_ff;
         s12_day_ff   <= s11_day_ff;
         s12_years_ff <= s11_years_ff;
         s12_milli_ff <= s11_milli_ff;
         s12_clamp_ff <= s11_clamp_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 13: estimate the minute.
   // ---------------------------------------------------------------
   logic [38:0] s13_prod;
   logic [5:0]  s13_min_ff, s13_min_in;
   logic [11:0] s13_remh_ff;
   logic [4:0]  s13_hour_ff;
   logic [3:0]  s13_month_ff;
   logic [4:0]  s13_day_ff;
   logic [7:0]  s13_years_ff;
   logic [9:0]  s13_milli_ff;
   logic        s13_clamp_ff;

   assign s13_prod   = 39'(s12_remh_ff) * 39'(RECIP_MIN);
   assign s13_min_in = s13_prod[37:32];

   always_ff @(posedge clock) begin
      if (stage_rdy[12]) begin
         s13_min_ff   <= s13_min_in;
         s13_remh_ff  <= s12_remh_ff;
         s13_hour_ff  <= s12_hour_ff;
         s13_month_ff <= s12_month_ff;
         s13_day_ff   <= s12_day_ff;
         s13_years_ff <= s12_years_ff;
         s13_milli_ff <= s12_milli_ff;
         s13_clamp_ff <= s12_clamp_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 14: correct the minute and second; this is the output register.
   // ---------------------------------------------------------------
   logic [11:0] s14_rest;
   logic        s14_fix;
   logic [5:0]  s14_min_ff, s14_min_in;
   logic [5:0]  s14_sec_ff, s14_sec_in;
   logic [4:0]  s14_hour_ff;
   logic [3:0]  s14_month_ff;
   logic [4:0]  s14_day_ff;
   logic [7:0]  s14_years_ff;
   logic [9:0]  s14_milli_ff;
   logic        s14_clamp_ff;

   assign s14_rest   = s13_remh_ff - 12'(s13_min_ff) * 12'(MIN_SEC);
   assign s14_fix    = s14_rest >= 12'(MIN_SEC);
   assign s14_min_in = s13_min_ff + 6'(s14_fix);
   assign s14_sec_in = s14_fix ? 6'(s14_rest - 12'(MIN_SEC)) : s14_rest[5:0];

   always_ff @(posedge clock) begin
      if (stage_rdy[13]) begin
         s14_min_ff   <= s14_min_in;
         s14_sec_ff   <= s14_sec_in;
         s14_hour_ff  <= s13_hour_ff;
         s14_month_ff <= s13_month_ff;
         s14_day_ff   <= s13_day_ff;
         s14_years_ff <= s13_years_ff;
         s14_milli_ff <= s13_milli_ff;
         s14_clamp_ff <= s13_clamp_ff;
      end
   end

   assign rsp_years_since_1970 = s14_years_ff;
   assign rsp_month_number     = s14_month_ff;
   assign rsp_day_of_month     = s14_day_ff;
   assign rsp_hour_of_day      = s14_hour_ff;
   assign rsp_minute_of_hour   = s14_min_ff;
   assign rsp_second_of_minute = s14_sec_ff;
   assign rsp_milli_part       = s14_milli_ff;
   assign rsp_was_clamped      = s14_clamp_ff;

endmodule

/* rtl/ems2cal_checker.sv */
module ems2cal_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_years_since_1970,
   input logic [3:0] rsp_month_number,
   input logic [4:0] rsp_day_of_month,
   input logic [4:0] rsp_hour_of_day,
   input logic [5:0] rsp_minute_of_hour,
   input logic [5:0] rsp_second_of_minute,
   input logic [9:0] rsp_milli_part,
   input logic       rsp_was_clamped
);
   import ems2cal_pkg::*;

   // The pipeline is empty in the cycle after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result item shown straight after reset");

   // A stalled result item holds its place and its year, day, millisecond and clamp fields.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_years_since_1970)
         && $stable(rsp_day_of_month) && $stable(rsp_milli_part)
         && $stable(rsp_was_clamped))
      else $error("stalled result item changed");

   // Every delivered field lies in its calendar range.
   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_month_number >= 4'd1 && rsp_month_number <= 4'd12
         && rsp_day_of_month >= 5'd1 && rsp_day_of_month <= 5'd31
         && rsp_hour_of_day <= 5'd23 && rsp_minute_of_hour <= 6'd59
         && rsp_second_of_minute <= 6'd59 && rsp_milli_part <= 10'd999
         && rsp_years_since_1970 <= MAX_YEARS)
      else $error("result field out of range");

   // A saturated item reads as the first instant of 2100.
   a_clamped_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_clamped |-> rsp_years_since_1970 == MAX_YEARS
         && rsp_month_number == 4'd1 && rsp_day_of_month == 5'd1
         && rsp_hour_of_day == 5'd0 && rsp_minute_of_hour == 6'd0
         && rsp_second_of_minute == 6'd0 && rsp_milli_part == 10'd0)
      else $error("saturated item is not 2100-01-01 00:00:00.000");

endmodule

bind epoch_ms_to_calendar ems2cal_checker u_ems2cal_checker (.*);
